FILE: hdl/tgi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trilinear grid interpolator package
// Shared constants, codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tgi_pkg;

   localparam int MAX_AXIS_POINTS_DEF = 16;
   localparam int FRAC_BITS_DEF       = 16;
   localparam int CUBE_DEPTH          = 4096;
   localparam int CUBE_AW             = 12;
   localparam int NUM_AXES            = 3;
   localparam int CSR_IDX_W           = 8;
   localparam int PTS_W               = 5;
   localparam int PT_W                = 16;
   localparam int VAL_W               = 32;
   localparam int LIDX_W              = 12;
   localparam int REQ_DATA_W          = 112;

   localparam logic [PTS_W-1:0] PTS_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] REG_POINTS_X = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_Y = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_Z = 8'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [2:0] LAST_CORNER  = 3'd7;
   localparam logic [2:0] FIRST_Y_STEP = 3'd4;
   localparam logic [2:0] LAST_BLEND   = 3'd6;

   typedef enum logic [1:0] {
      REQ_LOAD_POINT = 2'd0,
      REQ_LOAD_CUBE  = 2'd1,
      REQ_QUERY      = 2'd2
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_CLAMP,
      ST_SCAN,
      ST_SETUP,
      ST_DIV,
      ST_CN_ADDR,
      ST_CN_DATA,
      ST_BL_MUL,
      ST_BL_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       query_start;
      logic       lat_first;
      logic       lat_last;
      logic       scan_step;
      logic       scan_last;
      logic       ax_setup;
      logic       div_start;
      logic       frac_load;
      logic       corner_shift;
      logic       blend_mul;
      logic       blend_acc;
      logic       out_load;
      logic [1:0] axis;
      logic [2:0] step;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic div_done;
      logic rsp_full;
      logic hit;
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/trilinear_grid_interpolator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trilinear grid interpolator
// Non-uniform 3D grid lookup with fixed-point trilinear blending.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries load and query items; req_tuser selects the kind. Axis-point
//   and cube loads are written in the cycle they are taken.
//   A query gives one rsp_* item: rsp_tdata is the Q16.16 value, rsp_tuser
//   flags an exact grid hit. Loads and unknown kinds give no item.
//   csr_* writes the point count of each axis (index 0..2); write while idle.
// Query time is set by the axis table scan (one point a cycle from a
//   single-port memory), the bit-serial divider (only when an axis misses),
//   the eight corner reads through the single cube memory port and seven
//   blends (none on a hit). One query is in flight at a time.
// Reset clears control state and sets every point count to 16; table
//   contents are undefined until loaded.
// A stalled receiver holds the result in the output register; the block
//   keeps taking loads and works on the next query until it has a new result.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_top #(
   parameter int MAX_AXIS_POINTS = tgi_pkg::MAX_AXIS_POINTS_DEF,
   parameter int FRAC_BITS       = tgi_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // axis_sel, load_index, point_value, cube_value, dim_x, dim_y, dim_z
   input  wire logic [tgi_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // interp_value
   output logic [tgi_pkg::VAL_W-1:0]              rsp_tdata,
   // exact_hit
   output logic                                   rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tgi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tgi_pkg::PTS_W-1:0]         csr_data
);
   import tgi_pkg::*;

   localparam int IW = $clog2(MAX_AXIS_POINTS);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] rd_idx, cur_idx, last_idx;

   assign csr_ready = 1'b1;

   tgi_ctrl #(
      .MAX_AXIS_POINTS(MAX_AXIS_POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .status     (status),
      .last_idx   (last_idx),
      .cmd        (cmd),
      .rd_idx     (rd_idx),
      .cur_idx    (cur_idx)
   );

   tgi_dp #(
      .MAX_AXIS_POINTS(MAX_AXIS_POINTS),
      .FRAC_BITS      (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rd_idx      (rd_idx),
      .cur_idx     (cur_idx),
      .last_idx    (last_idx),
      .req_type    (req_tuser),
      .axis_sel    (req_tdata[1:0]),
      .load_index  (req_tdata[13:2]),
      .point_value (req_tdata[29:14]),
      .cube_value  (req_tdata[61:30]),
      .dim_x       (req_tdata[77:62]),
      .dim_y       (req_tdata[93:78]),
      .dim_z       (req_tdata[109:94]),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_value   (rsp_tdata),
      .rsp_hit     (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: hdl/tgi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider for (num << FRAC_BITS) / span, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tgi_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [tgi_pkg::PT_W-1:0] num,
   input  wire logic [tgi_pkg::PT_W-1:0] span,
   output logic                         done,
   output logic [FRAC_BITS:0]           quot
);
   import tgi_pkg::*;

   localparam int CW = $clog2(FRAC_BITS + 1);
   localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic              busy_ff, done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [PT_W-1:0]   rem_ff, span_ff, rem_in;
   logic [FRAC_BITS:0] quot_ff;
   logic [PT_W:0]     dbl;
   logic              ge;

   assign dbl    = {rem_ff, 1'b0};
   assign ge     = dbl >= {1'b0, span_ff};
   assign rem_in = ge ? PT_W'(dbl - {1'b0, span_ff}) : dbl[PT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // a flat span or a size at the upper point finishes at once
         done_ff <= start ? ((span == '0) || (num >= span))
                          : (busy_ff && (cnt_ff == CW'(1)));
         if (start) begin
            span_ff <= span;
            rem_ff  <= num;
            cnt_ff  <= CW'(FRAC_BITS);
            if (span == '0) begin
               quot_ff <= '0;
            end else if (num >= span) begin
               quot_ff <= FRAC_ONE;
            end else begin
               quot_ff <= '0;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[FRAC_BITS-1:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

FILE: hdl/tgi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolator datapath
// Axis and cube memories, point registers, axis search, corner fetch,
// fixed-point blend unit and the result register.
// ----------------------------------------------------------------------------
module tgi_dp #(
   parameter int MAX_AXIS_POINTS = 16,
   parameter int FRAC_BITS       = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tgi_pkg::cmd_type                 cmd,
   output tgi_pkg::status_type                   status,
   input  wire logic [$clog2(MAX_AXIS_POINTS)-1:0] rd_idx,
   input  wire logic [$clog2(MAX_AXIS_POINTS)-1:0] cur_idx,
   output logic [$clog2(MAX_AXIS_POINTS)-1:0]      last_idx,
   input  wire logic [1:0]                       req_type,
   input  wire logic [1:0]                       axis_sel,
   input  wire logic [tgi_pkg::LIDX_W-1:0]       load_index,
   input  wire logic [tgi_pkg::PT_W-1:0]         point_value,
   input  wire logic [tgi_pkg::VAL_W-1:0]        cube_value,
   input  wire logic [tgi_pkg::PT_W-1:0]         dim_x,
   input  wire logic [tgi_pkg::PT_W-1:0]         dim_y,
   input  wire logic [tgi_pkg::PT_W-1:0]         dim_z,
   input  wire logic                             csr_valid,
   input  wire logic [tgi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tgi_pkg::PTS_W-1:0]        csr_data,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_valid,
   output logic [tgi_pkg::VAL_W-1:0]             rsp_value,
   output logic                                  rsp_hit
);
   import tgi_pkg::*;

   localparam int IW  = $clog2(MAX_AXIS_POINTS);
   localparam int NW  = $clog2(MAX_AXIS_POINTS + 1);
   localparam int AW  = $clog2(NUM_AXES * MAX_AXIS_POINTS);
   localparam int CIW = (3 * NW > CUBE_AW + 1) ? 3 * NW : CUBE_AW + 1;
   localparam int FW  = FRAC_BITS + 1;
   localparam int PW  = FRAC_BITS + 34;
   localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW:0]   HALF =
      {{(PW - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   // memories
   logic [PT_W-1:0]  axis_mem [NUM_AXES * MAX_AXIS_POINTS];
   logic [VAL_W-1:0] cube_mem [CUBE_DEPTH];
   logic [PT_W-1:0]  ax_rd_ff;
   logic [VAL_W-1:0] cube_rd_ff;
   logic             oob_ff;
   logic [AW-1:0]    ax_wr_addr, ax_rd_addr;
   logic             ax_wr_en, cube_wr_en;

   // configuration and query
   logic [PTS_W-1:0] pts_ff [NUM_AXES];
   logic [NW-1:0]    n_use [NUM_AXES];
   logic [2*NW-1:0]  nynz_ff;
   logic [PT_W-1:0]  qdim_ff [NUM_AXES];

   // axis search
   logic [PT_W-1:0]  d_ff, first_ff, prev_ff, pl_ff, ph_ff, dim_cur, d_clamp;
   logic             match_ff, br_ff, hit_ff;
   logic [IW-1:0]    match_idx_ff, br_lo_ff;
   logic [IW-1:0]    lo_ff [NUM_AXES];
   logic [IW-1:0]    hi_ff [NUM_AXES];
   logic [FW-1:0]    frac_ff [NUM_AXES];
   logic [PT_W-1:0]  span, num_raw, num_c;
   logic             div_done;
   logic [FW-1:0]    div_quot;

   // corners and blend
   logic [IW-1:0]    cx, cy, cz;
   logic [CIW-1:0]   cidx;
   logic [VAL_W-1:0] q_ff [8];
   logic [FW-1:0]    fsel, omf;
   logic signed [PW-1:0] p1_in, p1_ff, p2;
   logic signed [PW:0]   acc;
   logic [VAL_W-1:0] blend_res;
   logic [2:0]       wr_pos;

   logic             rsp_valid_ff, rsp_hit_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   // ---------------- memories ----------------
   assign ax_wr_en   = cmd.accept && (req_type == REQ_LOAD_POINT) && (axis_sel < 2'd3)
                       && (load_index < LIDX_W'(MAX_AXIS_POINTS));
   assign cube_wr_en = cmd.accept && (req_type == REQ_LOAD_CUBE);
   assign ax_wr_addr = AW'(axis_sel) * AW'(MAX_AXIS_POINTS) + AW'(load_index[IW-1:0]);
   assign ax_rd_addr = AW'(cmd.axis) * AW'(MAX_AXIS_POINTS) + AW'(rd_idx);

   always_ff @(posedge clock) begin
      if (ax_wr_en) axis_mem[ax_wr_addr] <= point_value;
      ax_rd_ff <= axis_mem[ax_rd_addr];
   end

   assign cx   = cmd.step[0] ? hi_ff[AXIS_X] : lo_ff[AXIS_X];
   assign cy   = cmd.step[1] ? hi_ff[AXIS_Y] : lo_ff[AXIS_Y];
   assign cz   = cmd.step[2] ? hi_ff[AXIS_Z] : lo_ff[AXIS_Z];
   assign cidx = CIW'(cx) * CIW'(nynz_ff) + CIW'(cy) * CIW'(n_use[AXIS_Z]) + CIW'(cz);

   always_ff @(posedge clock) begin
      if (cube_wr_en) cube_mem[load_index] <= cube_value;
      cube_rd_ff <= cube_mem[cidx[CUBE_AW-1:0]];
      oob_ff     <= cidx >= CIW'(CUBE_DEPTH);
   end

   // ---------------- point-count registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) pts_ff[a] <= PTS_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_POINTS_X) pts_ff[AXIS_X] <= csr_data;
         if (csr_index == REG_POINTS_Y) pts_ff[AXIS_Y] <= csr_data;
         if (csr_index == REG_POINTS_Z) pts_ff[AXIS_Z] <= csr_data;
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (pts_ff[a] < PTS_W'(2))                 n_use[a] = NW'(2);
         else if (32'(pts_ff[a]) > MAX_AXIS_POINTS) n_use[a] = NW'(MAX_AXIS_POINTS);
         else                                       n_use[a] = NW'(pts_ff[a]);
      end
   end

   always_ff @(posedge clock) nynz_ff <= n_use[AXIS_Y] * n_use[AXIS_Z];

   assign last_idx = IW'(n_use[cmd.axis] - 1'b1);

   // ---------------- axis search ----------------
   assign dim_cur = qdim_ff[cmd.axis];
   always_comb begin
      if (dim_cur > ax_rd_ff)      d_clamp = ax_rd_ff;
      else if (dim_cur < first_ff) d_clamp = first_ff;
      else                         d_clamp = dim_cur;
   end

   assign span    = (ph_ff > pl_ff) ? PT_W'(ph_ff - pl_ff) : '0;
   assign num_raw = (d_ff > pl_ff) ? PT_W'(d_ff - pl_ff) : '0;
   assign num_c   = (num_raw > span) ? span : num_raw;

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         qdim_ff[AXIS_X] <= dim_x;
         qdim_ff[AXIS_Y] <= dim_y;
         qdim_ff[AXIS_Z] <= dim_z;
      end
      if (cmd.lat_first) first_ff <= ax_rd_ff;
      if (cmd.lat_last) d_ff <= d_clamp;
      if (cmd.scan_step) begin
         prev_ff <= ax_rd_ff;
         if (!match_ff && ax_rd_ff == d_ff) match_idx_ff <= cur_idx;
         // the first point above the size closes the bracket; failing that, the last point does
         if (cur_idx != '0 && !br_ff && (ax_rd_ff > d_ff || cmd.scan_last)) begin
            br_lo_ff <= IW'(cur_idx - 1'b1);
            pl_ff    <= prev_ff;
            ph_ff    <= ax_rd_ff;
         end
      end
      if (cmd.ax_setup) begin
         if (match_ff) begin
            lo_ff[cmd.axis]   <= match_idx_ff;
            hi_ff[cmd.axis]   <= match_idx_ff;
            frac_ff[cmd.axis] <= '0;
         end else begin
            lo_ff[cmd.axis] <= br_lo_ff;
            hi_ff[cmd.axis] <= IW'(br_lo_ff + 1'b1);
         end
      end
      if (cmd.frac_load) frac_ff[cmd.axis] <= div_quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         br_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (cmd.query_start) hit_ff <= 1'b1;
         if (cmd.lat_last) begin
            match_ff <= 1'b0;
            br_ff    <= 1'b0;
         end else if (cmd.scan_step) begin
            if (ax_rd_ff == d_ff) match_ff <= 1'b1;
            if (cur_idx != '0 && (ax_rd_ff > d_ff || cmd.scan_last)) br_ff <= 1'b1;
         end
         if (cmd.ax_setup && !match_ff) hit_ff <= 1'b0;
      end
   end

   tgi_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_c),
      .span  (span),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------- blend unit ----------------
   always_comb begin
      if (cmd.step < FIRST_Y_STEP)    fsel = frac_ff[AXIS_X];
      else if (cmd.step < LAST_BLEND) fsel = frac_ff[AXIS_Y];
      else                            fsel = frac_ff[AXIS_Z];
   end

   assign omf       = FRAC_ONE - fsel;
   assign p1_in     = $signed(q_ff[0]) * $signed({1'b0, omf});
   assign p2        = $signed(q_ff[1]) * $signed({1'b0, fsel});
   assign acc       = $signed({p1_ff[PW-1], p1_ff}) + $signed({p2[PW-1], p2}) + $signed(HALF);
   assign blend_res = acc[FRAC_BITS+VAL_W-1:FRAC_BITS];
   assign wr_pos    = LAST_BLEND - cmd.step;

   always_ff @(posedge clock) begin
      if (cmd.blend_mul) p1_ff <= p1_in;
      // corners enter at the tail in x-fastest order so each blend pairs the head two
      if (cmd.corner_shift) begin
         for (int i = 0; i < 7; i++) q_ff[i] <= q_ff[i+1];
         q_ff[7] <= oob_ff ? '0 : cube_rd_ff;
      end else if (cmd.blend_acc) begin
         for (int i = 0; i < 6; i++) q_ff[i] <= (3'(i) == wr_pos) ? blend_res : q_ff[i+2];
         if (wr_pos == LAST_BLEND) q_ff[6] <= blend_res;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff <= q_ff[0];
         rsp_hit_ff   <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_hit   = rsp_hit_ff;

   assign status.match    = match_ff;
   assign status.div_done = div_done;
   assign status.rsp_full = rsp_valid_ff && !rsp_tready;
   assign status.hit      = hit_ff;

   assert property (@(posedge clock) disable iff (reset) cmd.ax_setup |-> br_ff)
      else $error("axis bracket missing at setup");
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("result changed while stalled");

endmodule
`default_nettype wire

FILE: hdl/tgi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolator controller
// Sequences loads, the per-axis search and divide, corner fetch and blends.
// ----------------------------------------------------------------------------
module tgi_ctrl #(
   parameter int MAX_AXIS_POINTS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [1:0]                         req_type,
   input  wire tgi_pkg::status_type                status,
   input  wire logic [$clog2(MAX_AXIS_POINTS)-1:0] last_idx,
   output tgi_pkg::cmd_type                        cmd,
   output logic [$clog2(MAX_AXIS_POINTS)-1:0]      rd_idx,
   output logic [$clog2(MAX_AXIS_POINTS)-1:0]      cur_idx
);
   import tgi_pkg::*;

   localparam int IW = $clog2(MAX_AXIS_POINTS);

   state_type     state_ff, state_in;
   logic [1:0]    axis_ff, axis_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [2:0]    step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
         cnt_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      cmd        = '0;
      cmd.axis   = axis_ff;
      cmd.step   = step_ff;
      rd_idx     = '0;
      cur_idx    = cnt_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_type == REQ_QUERY) begin
                  cmd.query_start = 1'b1;
                  axis_in         = AXIS_X;
                  state_in        = ST_RD_FIRST;
               end
            end
         end
         ST_RD_FIRST: state_in = ST_RD_LAST;
         ST_RD_LAST: begin
            cmd.lat_first = 1'b1;
            rd_idx        = last_idx;
            state_in      = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.lat_last = 1'b1;
            cnt_in       = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_last = (cnt_ff == last_idx);
            rd_idx        = IW'(cnt_ff + 1'b1);
            if (cnt_ff == last_idx) state_in = ST_SETUP;
            else                    cnt_in   = IW'(cnt_ff + 1'b1);
         end
         ST_SETUP: begin
            cmd.ax_setup = 1'b1;
            if (status.match) begin
               if (axis_ff == AXIS_Z) begin
                  step_in  = '0;
                  state_in = ST_CN_ADDR;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_RD_FIRST;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.frac_load = 1'b1;
               if (axis_ff == AXIS_Z) begin
                  step_in  = '0;
                  state_in = ST_CN_ADDR;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_RD_FIRST;
               end
            end
         end
         ST_CN_ADDR: state_in = ST_CN_DATA;
         ST_CN_DATA: begin
            cmd.corner_shift = 1'b1;
            if (step_ff == LAST_CORNER) begin
               step_in  = '0;
               state_in = status.hit ? ST_OUT : ST_BL_MUL;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_CN_ADDR;
            end
         end
         ST_BL_MUL: begin
            cmd.blend_mul = 1'b1;
            state_in      = ST_BL_ACC;
         end
         ST_BL_ACC: begin
            cmd.blend_acc = 1'b1;
            if (step_ff == LAST_BLEND) begin
               state_in = ST_OUT;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_BL_MUL;
            end
         end
         ST_OUT: begin
            if (!status.rsp_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= last_idx)
      else $error("scan index beyond last used point");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BL_MUL |-> !status.hit)
      else $error("blend started on an exact hit");

endmodule
`default_nettype wire
